// ----- src/rencd_pkg.sv -----
// Shared types, codes and the Gray-code transition table for the rotary
// encoder detent event block. No dependencies.
`default_nettype none

package rencd_pkg;

    // Tick counter width and its saturation value
    localparam int unsigned TICK_BITS = 16;
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // Configuration register widths, indexes and reset values
    localparam int unsigned DEBOUNCE_BITS = 10;
    localparam int unsigned DETENT_BITS   = 4;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 10;

    localparam logic [CFG_IDX_BITS-1:0]  CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0]  CFG_DETENT   = 2'd1;
    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RST = 10'd50;
    localparam logic [DETENT_BITS-1:0]   DETENT_RST   = 4'd2;

    // Event codes on the result beat
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_UP    = 2'd1,
        EV_DOWN  = 2'd2,
        EV_CLICK = 2'd3
    } t_event;

    // Direction of one phase transition
    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_INC  = 2'd1,
        DIR_DEC  = 2'd2
    } t_dir;

    // One input beat
    typedef struct packed {
        logic phase_a;
        logic phase_b;
        logic key_level;
        logic poll;
    } t_item;

    // One result beat
    typedef struct packed {
        t_event event_res;
        logic   key_pressed;
    } t_result;

    // Configuration seen by the step logic
    typedef struct packed {
        logic [DEBOUNCE_BITS-1:0] debounce_ticks;
        logic [DETENT_BITS-1:0]   detent_steps;
    } t_cfg;

    // Transition table indexed by {last phase, new phase}, A the high bit
    function automatic t_dir gray_dir(input logic [3:0] idx);
        t_dir d;
        case (idx)
            4'b0001, 4'b0111, 4'b1000, 4'b1110: d = DIR_INC;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_DEC;
            default:                            d = DIR_HOLD;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- src/rencd_step.sv -----
// Per-tick state and update logic: phase tracking, saturating step count,
// key debounce and detent event selection. Depends on rencd_pkg.
`default_nettype none

module rencd_step
    import rencd_pkg::*;
#(
    parameter int unsigned STEP_COUNT_BITS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_cfg    i_cfg,
    input  wire t_item   i_item,
    output t_result      o_res
);

    localparam int unsigned W  = STEP_COUNT_BITS;
    localparam int unsigned WX = STEP_COUNT_BITS + 5;

    localparam logic [W-1:0] CNT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] CNT_MIN = {1'b1, {(W-1){1'b0}}};

    logic [1:0]           r_last_phase;
    logic [W-1:0]         r_cnt;
    logic                 r_key_raw;
    logic                 r_key_stable;
    logic [TICK_BITS-1:0] r_tsc;

    logic [1:0]           n_last_phase;
    logic [W-1:0]         n_cnt;
    logic                 n_key_raw;
    logic                 n_key_stable;
    logic [TICK_BITS-1:0] n_tsc;

    logic [1:0]             w_phase;
    t_dir                   w_dir;
    logic [W-1:0]           w_cnt_a;
    logic [DETENT_BITS-1:0] w_det;
    logic signed [WX-1:0]   w_cnt_x;
    logic signed [WX-1:0]   w_det_x;
    logic                   w_up;
    logic                   w_down;
    logic [TICK_BITS-1:0]   w_tsc_eff;
    logic                   w_stable_ok;
    logic                   w_click;

    // Phase transition and saturating step count
    always_comb begin
        w_phase = {i_item.phase_a, i_item.phase_b};
        w_dir   = gray_dir({r_last_phase, w_phase});
        w_cnt_a = r_cnt;
        if (w_dir == DIR_INC && r_cnt != CNT_MAX) begin
            w_cnt_a = r_cnt + W'(1);
        end else if (w_dir == DIR_DEC && r_cnt != CNT_MIN) begin
            w_cnt_a = r_cnt - W'(1);
        end
    end

    // Detent threshold compare, zero detent counts as one
    always_comb begin
        w_det   = (i_cfg.detent_steps == '0) ? DETENT_BITS'(1) : i_cfg.detent_steps;
        w_cnt_x = signed'({{(WX-W){w_cnt_a[W-1]}}, w_cnt_a});
        w_det_x = signed'({{(WX-DETENT_BITS){1'b0}}, w_det});
        w_up    = (w_cnt_x >= w_det_x);
        w_down  = (w_cnt_x <= -w_det_x);
    end

    // Key debounce on poll ticks
    always_comb begin
        w_tsc_eff   = (i_item.poll && i_item.key_level != r_key_raw) ? '0 : r_tsc;
        w_stable_ok = i_item.poll &&
                      (w_tsc_eff >= {{(TICK_BITS-DEBOUNCE_BITS){1'b0}}, i_cfg.debounce_ticks});
        w_click     = w_stable_ok && i_item.key_level && !r_key_stable;
    end

    // Next state and result selection
    always_comb begin
        n_last_phase = w_phase;
        n_key_raw    = i_item.poll ? i_item.key_level : r_key_raw;
        n_key_stable = w_stable_ok ? i_item.key_level : r_key_stable;
        n_tsc        = (w_tsc_eff == TICK_MAX) ? w_tsc_eff : w_tsc_eff + TICK_BITS'(1);
        n_cnt        = w_cnt_a;
        o_res.event_res   = EV_NONE;
        o_res.key_pressed = !i_item.key_level;
        if (i_item.poll) begin
            if (w_click) begin
                o_res.event_res = EV_CLICK;
            end else if (w_up) begin
                o_res.event_res = EV_UP;
                n_cnt = W'(w_cnt_x - w_det_x);
            end else if (w_down) begin
                o_res.event_res = EV_DOWN;
                n_cnt = W'(w_cnt_x + w_det_x);
            end
        end
    end

    // Commit state when the beat moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= '0;
            r_cnt        <= '0;
            r_key_raw    <= 1'b1;
            r_key_stable <= 1'b1;
            r_tsc        <= '0;
        end else if (i_fire) begin
            r_last_phase <= n_last_phase;
            r_cnt        <= n_cnt;
            r_key_raw    <= n_key_raw;
            r_key_stable <= n_key_stable;
            r_tsc        <= n_tsc;
        end
    end

endmodule

`default_nettype wire

// ----- src/rotary_encoder_detent_events.sv -----
// An accepted input beat passes the input register and the step logic into the result
// register. Throughput: one beat per cycle unless the master stalls; input and result
// registers each hold one beat, so input is taken while a finished result waits.
// Reset (i_rst_n low, synchronous): clears both registers' valid flags, the encoder
// and key state, and sets debounce_ticks to 50 and detent_steps to 2.
// Top level: input register, step logic (rencd_step), result register, config port.
`default_nettype none

module rotary_encoder_detent_events
    import rencd_pkg::*;
#(
    parameter int unsigned STEP_COUNT_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Config write port
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // Slave side
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    input  wire logic [7:0]               i_s_tdata,  // [0] phase_a, [1] phase_b,
                                                       // [2] key_level, [3] poll
    // Master side
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    output logic [7:0]                    o_m_tdata   // [1:0] event_res, [2] key_pressed
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;

    logic    w_advance;
    t_result w_res;

    // Config registers, out-of-range indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.detent_steps   <= DETENT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DEBOUNCE) begin
                r_cfg.debounce_ticks <= i_cfg_data[DEBOUNCE_BITS-1:0];
            end else if (i_cfg_idx == CFG_DETENT) begin
                r_cfg.detent_steps <= i_cfg_data[DETENT_BITS-1:0];
            end
        end
    end

    // Move a beat forward when the result register is free or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_item.phase_a   <= i_s_tdata[0];
            r_in_item.phase_b   <= i_s_tdata[1];
            r_in_item.key_level <= i_s_tdata[2];
            r_in_item.poll      <= i_s_tdata[3];
        end
    end

    rencd_step #(
        .STEP_COUNT_BITS(STEP_COUNT_BITS)
    ) u_step (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (w_advance),
        .i_cfg  (r_cfg),
        .i_item (r_in_item),
        .o_res  (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_res.key_pressed, r_out_res.event_res};

`ifndef ASSERT_OFF
    // A click needs the key released on that tick
    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.event_res == EV_CLICK) |-> !r_out_res.key_pressed)
        else $error("click reported with key pressed");

    // Backpressure only while a beat waits in the input register
    a_stall_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid)
        else $error("input stalled with empty input register");

    // A beat that cannot advance stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input beat lost while stalled");
`endif

endmodule

`default_nettype wire

// ----- verif/rotary_encoder_detent_events_tb.sv -----
// Self-checking bench for rotary_encoder_detent_events: detent and click prediction on
// stream beats under random idling, register sweeps and long one-way turns.
// Depends on rencd_pkg and the rotary_encoder_detent_events top level.
module rotary_encoder_detent_events_tb;
    import rencd_pkg::*;

    localparam int STEP_BITS    = 16;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SPIN_TICKS   = 24;
    // Gray order of the phase pair {A,B}; the table is its own inverse
    localparam int GRAY_ORDER[4] = '{0, 1, 3, 2};

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [7:0]               i_s_tdata  = '0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [7:0]               o_m_tdata;

    rotary_encoder_detent_events #(
        .STEP_COUNT_BITS(STEP_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Predicts the event of every accepted tick and checks result beats in order
    class enc_scoreboard;
        t_result                  due_events[$];
        int                       n_fail;
        int                       n_ticks;
        int                       n_up;
        int                       n_down;
        int                       n_click;
        logic [1:0]               prev_phase;
        int                       steps;
        logic                     key_raw;
        logic                     key_stable;
        int                       tick_age;
        logic [DEBOUNCE_BITS-1:0] debounce;
        logic [DETENT_BITS-1:0]   detent;

        function new();
            prev_phase = 2'b00;
            steps      = 0;
            key_raw    = 1'b1;
            key_stable = 1'b1;
            tick_age   = 0;
            debounce   = 10'd50;
            detent     = 4'd2;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_DEBOUNCE: debounce = data[DEBOUNCE_BITS-1:0];
                CFG_DETENT:   detent   = data[DETENT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void predict_tick(t_item it);
            logic [1:0] phase;
            int         hop;
            int         step_max;
            int         need;
            logic       click;
            t_result    r;
            phase    = {it.phase_a, it.phase_b};
            step_max = (1 << (STEP_BITS - 1)) - 1;
            r.event_res = EV_NONE;
            // Phase tracking: one Gray step forward or back, a double jump counts zero
            if (phase != prev_phase) begin
                hop = (GRAY_ORDER[phase] - GRAY_ORDER[prev_phase]) & 3;
                if (hop == 1)
                    steps = steps + 1;
                else if (hop == 3)
                    steps = steps - 1;
                if (steps > step_max)
                    steps = step_max;
                if (steps < -step_max - 1)
                    steps = -step_max - 1;
                prev_phase = phase;
            end
            // Key debounce, then detent only if no click
            if (it.poll) begin
                click = 1'b0;
                if (it.key_level != key_raw) begin
                    tick_age = 0;
                    key_raw  = it.key_level;
                end
                if (tick_age >= int'(debounce)) begin
                    click      = it.key_level && !key_stable;
                    key_stable = it.key_level;
                end
                need = (detent == 0) ? 1 : int'(detent);
                if (click) begin
                    r.event_res = EV_CLICK;
                end else if (steps >= need) begin
                    steps       = steps - need;
                    r.event_res = EV_UP;
                end else if (steps <= -need) begin
                    steps       = steps + need;
                    r.event_res = EV_DOWN;
                end
            end
            if (tick_age < int'(TICK_MAX))
                tick_age++;
            r.key_pressed = !it.key_level;
            due_events.push_back(r);
            n_ticks++;
        endfunction

        function void check_result(logic [7:0] beat);
            t_result want;
            if (due_events.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("[%0t] result beat %h with nothing expected", $time, beat);
                return;
            end
            want = due_events.pop_front();
            if (beat[1:0] != want.event_res || beat[2] != want.key_pressed
                    || beat[7:3] != 5'd0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("[%0t] expected event %0d key %0b, got event %0d key %0b pad %h",
                             $time, want.event_res, want.key_pressed,
                             beat[1:0], beat[2], beat[7:3]);
            end
            case (want.event_res)
                EV_UP:    n_up++;
                EV_DOWN:  n_down++;
                EV_CLICK: n_click++;
                default: ;
            endcase
        endfunction
    endclass

    enc_scoreboard sb;
    int  cycle_count  = 0;
    int  rx_hold      = 0;
    bit  tx_gaps_on   = 1'b1;
    bit  rx_stall_on  = 1'b1;
    int  enc_pos      = 0;
    int  spin_dir     = 1;
    bit  key_lvl      = 1'b1;
    int  key_hold     = 0;
    int  cur_debounce = 50;
    int  n_settings   = 1;

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Result side backpressure
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
            rx_hold    <= pick_idle();
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.predict_tick(t_item'({i_s_tdata[0], i_s_tdata[1], i_s_tdata[2],
                                         i_s_tdata[3]}));
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata);
        end
    end

    function automatic t_item make_tick(int pos, bit key, bit poll);
        t_item it;
        logic [1:0] phase;
        phase        = 2'(GRAY_ORDER[pos & 3]);
        it.phase_a   = phase[1];
        it.phase_b   = phase[0];
        it.key_level = key;
        it.poll      = poll;
        return it;
    endfunction

    // Offer one tick beat and hold it until taken
    task automatic send_tick(t_item it, bit steady);
        int gap;
        gap = (steady || !tx_gaps_on) ? 0 : pick_idle();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, it.poll, it.key_level, it.phase_b, it.phase_a};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Let the monitor note the last accepted beat, then wait for every result
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Write both registers; upper data bits of the detent write are junk
    task automatic set_timing(int deb, int det);
        write_reg(CFG_DEBOUNCE, 10'(deb));
        write_reg(CFG_DETENT, {6'($urandom), 4'(det)});
        cur_debounce = deb;
        n_settings++;
    endtask

    // Continuous turn in one direction, key held, no gaps
    task automatic spin_run(int n, int dir, bit key);
        repeat (n) begin
            enc_pos = (enc_pos + dir) & 3;
            send_tick(make_tick(enc_pos, key, 1'b0), 1'b1);
        end
    endtask

    // Mostly legal turning with bouncing key presses, some jumps and noise
    task automatic run_random(int n);
        int r;
        bit poll;
        for (int k = 0; k < n; k++) begin
            if (k % 100 == 0) begin
                tx_gaps_on  = $urandom_range(0, 3) != 0;
                rx_stall_on = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 149) == 0)
                wait_drained();
            if ($urandom_range(0, 99) < 8)
                spin_dir = -spin_dir;
            r = $urandom_range(0, 99);
            if (r < 65)
                enc_pos = (enc_pos + spin_dir) & 3;
            else if (r < 95 && r >= 90)
                enc_pos = (enc_pos + 2) & 3;
            else if (r >= 95)
                enc_pos = $urandom_range(0, 3);
            if (key_hold == 0) begin
                key_lvl  = ~key_lvl;
                key_hold = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3)
                                                      : $urandom_range(1, 2 * cur_debounce + 20);
            end
            key_hold--;
            poll = $urandom_range(0, 99) < 40;
            send_tick(make_tick(enc_pos, key_lvl, poll), 1'b0);
        end
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values
        run_random(150);
        wait_drained();

        // Directed: every field pattern, steps both ways, jump, instant debounce, click first
        set_timing(0, 1);
        for (int v = 0; v < 16; v++)
            send_tick(t_item'({v[0], v[1], v[2], v[3]}), 1'b0);
        send_tick(t_item'(4'b1011), 1'b0);
        send_tick(t_item'(4'b1111), 1'b0);
        send_tick(t_item'(4'b0011), 1'b0);
        send_tick(t_item'(4'b0001), 1'b0);
        send_tick(t_item'(4'b0000), 1'b0);
        send_tick(t_item'(4'b0111), 1'b0);
        send_tick(t_item'(4'b0111), 1'b0);
        enc_pos = 1;
        wait_drained();

        // Detent zero behaves as one
        set_timing(0, 0);
        run_random(200);
        wait_drained();

        set_timing(3, 4);
        run_random(300);
        wait_drained();

        set_timing(1, 8);
        run_random(250);
        wait_drained();

        // Long one-way turns with the key held down, large detent, junk register indexes
        set_timing(1023, 15);
        write_reg(2'd2, 10'($urandom));
        write_reg(2'd3, 10'($urandom));
        rx_stall_on = 1'b0;
        send_tick(make_tick(enc_pos, 1'b0, 1'b1), 1'b1);
        spin_run(SPIN_TICKS, 1, 1'b0);
        repeat (4) send_tick(make_tick(enc_pos, 1'b0, 1'b1), 1'b1);
        spin_run(SPIN_TICKS, -1, 1'b0);
        repeat (4) send_tick(make_tick(enc_pos, 1'b1, 1'b1), 1'b1);
        wait_drained();
        rx_stall_on = 1'b1;

        set_timing(7, 9);
        run_random(250);
        wait_drained();

        set_timing($urandom_range(0, 20), $urandom_range(0, 15));
        run_random(300);
        wait_drained();

        set_timing(1023, 1);
        run_random(100);
        wait_drained();

        set_timing(2, 3);
        run_random(100);
        wait_drained();

        sb.n_fail += sb.due_events.size();
        $display("Covered %0d ticks over %0d register settings,", sb.n_ticks, n_settings);
        $display("with long one-way turns and ignored register indexes");
        $display("Events checked: %0d up, %0d down, %0d click; %0d errors",
                 sb.n_up, sb.n_down, sb.n_click, sb.n_fail);
        if (sb.n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
